/* sv/socc_pkg.sv */
// Shared types and constants for the second-order cone check block.
// Used by socc_isqrt, socc_datapath, socc_ctrl and the top level.
`default_nettype none

package socc_pkg;

    localparam int DEF_VALUE_WIDTH   = 32;
    localparam int DEF_FRACTION_BITS = 24;
    localparam int DEF_INDEX_WIDTH   = 16;
    localparam int DEF_MAX_CONE_SIZE = 255;

    localparam int TAG_WIDTH    = 12;
    localparam int TOL_WIDTH    = 25;
    localparam int ACC_WIDTH    = 64;
    localparam int ROOT_WIDTH   = 32;
    localparam int STATUS_WIDTH = 2;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 25'd17;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_FEASIBLE  = 2'd0,
        STATUS_PROJECTED = 2'd1,
        STATUS_SHORT     = 2'd2
    } status_code_t;

    typedef enum logic [1:0] {
        MUL_TAIL  = 2'd0,
        MUL_CROSS = 2'd1,
        MUL_DIFF  = 2'd2
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_ITEM       = 4'd1,
        ST_ACCUM      = 4'd2,
        ST_DECIDE     = 4'd3,
        ST_CROSS      = 4'd4,
        ST_ROT_TEST   = 4'd5,
        ST_DIFF       = 4'd6,
        ST_ROOT_START = 4'd7,
        ST_ROOT_WAIT  = 4'd8,
        ST_FINISH     = 4'd9
    } ctrl_state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     cross_en;
        logic     rot_test_en;
        logic     rad_en;
        logic     root_start;
        logic     root_from_rad;
        logic     verdict_en;
    } dp_cmd_t;

    typedef struct packed {
        logic item_last;
        logic item_tail;
        logic item_rotated;
        logic item_short;
        logic rot_infeasible;
        logic root_done;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

/* sv/socc_isqrt.sv */
// Iterative floor square root of a 64-bit value, one root bit per cycle.
// Depends on socc_pkg for the radicand and root widths.
`default_nettype none

module socc_isqrt (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [socc_pkg::ACC_WIDTH-1:0]   radicand,
    output logic                                  busy,
    output logic [socc_pkg::ROOT_WIDTH-1:0]       root
);

    localparam int RW    = socc_pkg::ROOT_WIDTH;
    localparam int AW    = socc_pkg::ACC_WIDTH;
    localparam int REM_W = RW + 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic [AW-1:0]    rad_reg,   rad_next;
    logic [REM_W-1:0] rem_reg,   rem_next;
    logic [RW-1:0]    root_reg,  root_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg,  busy_next;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        rem_sh     = {rem_reg[REM_W-3:0], rad_reg[AW-1:AW-2]};
        trial      = {root_reg, 2'b01};
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            rad_next   = radicand;
            rem_next   = '0;
            root_next  = '0;
            count_next = CNT_W'(RW);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* sv/socc_datapath.sv */
// Datapath: cone state, shared multiplier, tail accumulator, verdict and output register.
// Depends on socc_pkg and socc_isqrt; driven by socc_ctrl through dp_cmd_t.
`default_nettype none

module socc_datapath #(
    parameter int VALUE_WIDTH   = socc_pkg::DEF_VALUE_WIDTH,
    parameter int FRACTION_BITS = socc_pkg::DEF_FRACTION_BITS,
    parameter int INDEX_WIDTH   = socc_pkg::DEF_INDEX_WIDTH,
    parameter int MAX_CONE_SIZE = socc_pkg::DEF_MAX_CONE_SIZE
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire socc_pkg::dp_cmd_t                     cmd,
    output socc_pkg::dp_status_t                       stat,
    input  wire logic                                  cfg_write,
    input  wire logic [socc_pkg::TOL_WIDTH-1:0]        cfg_data,
    input  wire logic                                  cone_kind,
    input  wire logic [socc_pkg::TAG_WIDTH-1:0]        cone_tag,
    input  wire logic [INDEX_WIDTH-1:0]                member_index,
    input  wire logic signed [VALUE_WIDTH-1:0]         element_value,
    input  wire logic                                  last_element,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [socc_pkg::TAG_WIDTH-1:0]             result_tag,
    output logic [socc_pkg::STATUS_WIDTH-1:0]          status,
    output logic [INDEX_WIDTH-1:0]                     lead_first_index,
    output logic signed [VALUE_WIDTH-1:0]              lead_first_value,
    output logic [INDEX_WIDTH-1:0]                     lead_second_index,
    output logic signed [VALUE_WIDTH-1:0]              lead_second_value
);

    localparam int AW     = socc_pkg::ACC_WIDTH;
    localparam int RW     = socc_pkg::ROOT_WIDTH;
    localparam int TW     = socc_pkg::TOL_WIDTH;
    localparam int POS_W  = $clog2(MAX_CONE_SIZE + 1);
    localparam int MUL_W  = VALUE_WIDTH + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int TOLQ_W = TW + FRACTION_BITS;
    localparam int CMP_W  = AW + 2;

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_CONE_SIZE);
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TWO   = POS_W'(2);
    localparam logic [AW-1:0]    ACC_MAX   = '1;
    localparam logic signed [CMP_W-1:0] VMAX_POS =
        (CMP_W'(1) << (VALUE_WIDTH - 1)) - CMP_W'(1);

    function automatic logic [MUL_W-1:0] mag_f(input logic signed [MUL_W-1:0] v);
        mag_f = v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
    endfunction

    function automatic logic [AW-1:0] sat_add_f(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add_f = s[AW] ? ACC_MAX : s[AW-1:0];
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] sat_pos_f(input logic signed [CMP_W-1:0] v);
        sat_pos_f = (v > VMAX_POS) ? VMAX_POS[VALUE_WIDTH-1:0] : v[VALUE_WIDTH-1:0];
    endfunction

    // halve a signed value, clip below at zero and above at the largest value
    function automatic logic [VALUE_WIDTH-1:0] half_clip_f(input logic signed [CMP_W-1:0] v);
        logic signed [CMP_W-1:0] h;
        h = v >>> 1;
        half_clip_f = v[CMP_W-1] ? '0 : sat_pos_f(h);
    endfunction

    // item and cone registers
    logic [TW-1:0]                 tol_reg;
    logic signed [VALUE_WIDTH-1:0] x_reg;
    logic                          kind_reg;
    logic [socc_pkg::TAG_WIDTH-1:0] tag_reg;
    logic                          last_reg;
    logic                          tail_reg;
    logic                          short_reg;
    logic [POS_W-1:0]              pos_reg;
    logic signed [VALUE_WIDTH-1:0] first_val_reg;
    logic signed [VALUE_WIDTH-1:0] second_val_reg;
    logic [INDEX_WIDTH-1:0]        first_idx_reg;
    logic [INDEX_WIDTH-1:0]        second_idx_reg;
    logic [AW-1:0]                 sum_reg;
    logic [AW-1:0]                 prod_reg;
    logic [AW-1:0]                 cross_reg;
    logic [AW-1:0]                 rad_reg;
    logic                          rot_inf_reg;

    logic                          out_valid_reg;
    logic [socc_pkg::TAG_WIDTH-1:0] out_tag_reg;
    logic [socc_pkg::STATUS_WIDTH-1:0] out_status_reg;
    logic [INDEX_WIDTH-1:0]        out_i1_reg;
    logic [INDEX_WIDTH-1:0]        out_i2_reg;
    logic [VALUE_WIDTH-1:0]        out_v1_reg;
    logic [VALUE_WIDTH-1:0]        out_v2_reg;

    // combinational
    logic                          tail_now;
    logic signed [MUL_W-1:0]       d_val;
    logic [MUL_W-1:0]              op_a;
    logic [MUL_W-1:0]              op_b;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W+AW-1:0]          prod_ext;
    logic [AW-1:0]                 prod_sat;
    logic [TOLQ_W-1:0]             tolq_full;
    logic [TOLQ_W+AW-1:0]          tolq_ext;
    logic [AW-1:0]                 tolq;
    logic                          cross_neg;
    logic                          rot_inf;
    logic                          root_busy;
    logic [RW-1:0]                 root;
    logic signed [CMP_W-1:0]       root_s;
    logic signed [CMP_W-1:0]       d_s;
    logic signed [CMP_W-1:0]       lhs_s;
    logic                          plain_inf;
    socc_pkg::status_code_t        verdict_status;
    logic [INDEX_WIDTH-1:0]        verdict_i2;
    logic [VALUE_WIDTH-1:0]        verdict_v1;
    logic [VALUE_WIDTH-1:0]        verdict_v2;

    assign tail_now = cone_kind ? (pos_reg >= POS_TWO) : (pos_reg >= POS_ONE);

    assign d_val = MUL_W'(second_val_reg) - MUL_W'(first_val_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            socc_pkg::MUL_TAIL:
            begin
                op_a = mag_f(MUL_W'(x_reg));
                op_b = op_a;
            end
            socc_pkg::MUL_CROSS:
            begin
                op_a = mag_f(MUL_W'(first_val_reg));
                op_b = mag_f(MUL_W'(second_val_reg));
            end
            socc_pkg::MUL_DIFF:
            begin
                op_a = mag_f(d_val);
                op_b = op_a;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod     = PROD_W'(op_a) * PROD_W'(op_b);
    assign prod_ext = {{AW{1'b0}}, prod};
    assign prod_sat = ((prod_ext >> AW) != '0) ? ACC_MAX : prod_ext[AW-1:0];

    assign tolq_full = TOLQ_W'(tol_reg) << FRACTION_BITS;
    assign tolq_ext  = {{AW{1'b0}}, tolq_full};
    assign tolq      = ((tolq_ext >> AW) != '0) ? ACC_MAX : tolq_ext[AW-1:0];

    assign cross_neg = (first_val_reg[VALUE_WIDTH-1] != second_val_reg[VALUE_WIDTH-1])
                       && (cross_reg != '0);

    always_comb
    begin
        if (!cross_neg)
        begin
            rot_inf = sat_add_f(cross_reg, tolq) < sum_reg;
        end
        else if (cross_reg > tolq)
        begin
            rot_inf = 1'b1;
        end
        else if (cross_reg == tolq)
        begin
            rot_inf = sum_reg != '0;
        end
        else
        begin
            rot_inf = (tolq - cross_reg) < sum_reg;
        end
    end

    socc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (cmd.root_from_rad ? rad_reg : sum_reg),
        .busy     (root_busy),
        .root     (root)
    );

    assign root_s    = signed'(CMP_W'(root));
    assign d_s       = CMP_W'(d_val);
    assign lhs_s     = CMP_W'(first_val_reg) + signed'(CMP_W'(tol_reg));
    assign plain_inf = lhs_s < root_s;

    always_comb
    begin
        verdict_status = socc_pkg::STATUS_FEASIBLE;
        verdict_i2     = '0;
        verdict_v1     = '0;
        verdict_v2     = '0;
        if (!kind_reg)
        begin
            if (plain_inf)
            begin
                verdict_status = socc_pkg::STATUS_PROJECTED;
                verdict_v1     = sat_pos_f(root_s);
            end
        end
        else if (short_reg)
        begin
            verdict_status = socc_pkg::STATUS_SHORT;
        end
        else
        begin
            verdict_i2 = second_idx_reg;
            if (rot_inf_reg)
            begin
                verdict_status = socc_pkg::STATUS_PROJECTED;
                verdict_v1     = half_clip_f(root_s - d_s);
                verdict_v2     = half_clip_f(root_s + d_s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg        <= socc_pkg::TOL_RESET;
            pos_reg        <= '0;
            sum_reg        <= '0;
            first_val_reg  <= '0;
            second_val_reg <= '0;
            first_idx_reg  <= '0;
            second_idx_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                tol_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                if (pos_reg == '0)
                begin
                    first_val_reg <= element_value;
                    first_idx_reg <= member_index;
                end
                else if (pos_reg == POS_ONE)
                begin
                    second_val_reg <= element_value;
                    second_idx_reg <= member_index;
                end
                if (pos_reg < POS_MAX)
                begin
                    pos_reg <= pos_reg + POS_ONE;
                end
            end
            if (cmd.acc_en)
            begin
                sum_reg <= sat_add_f(sum_reg, prod_reg);
            end
            // load the verdict and start a fresh cone
            if (cmd.verdict_en)
            begin
                out_valid_reg  <= 1'b1;
                pos_reg        <= '0;
                sum_reg        <= '0;
                first_val_reg  <= '0;
                second_val_reg <= '0;
                first_idx_reg  <= '0;
                second_idx_reg <= '0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= element_value;
            kind_reg  <= cone_kind;
            tag_reg   <= cone_tag;
            last_reg  <= last_element;
            tail_reg  <= tail_now;
            short_reg <= cone_kind && (pos_reg == '0);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_sat;
        end
        if (cmd.cross_en)
        begin
            cross_reg <= sat_add_f(prod_reg, prod_reg);
        end
        if (cmd.rot_test_en)
        begin
            rot_inf_reg <= rot_inf;
        end
        if (cmd.rad_en)
        begin
            rad_reg <= sat_add_f(prod_reg, sat_add_f(sum_reg, sum_reg));
        end
        if (cmd.verdict_en)
        begin
            out_tag_reg    <= tag_reg;
            out_status_reg <= verdict_status;
            out_i1_reg     <= first_idx_reg;
            out_i2_reg     <= verdict_i2;
            out_v1_reg     <= verdict_v1;
            out_v2_reg     <= verdict_v2;
        end
    end

    assign stat.item_last      = last_reg;
    assign stat.item_tail      = tail_reg;
    assign stat.item_rotated   = kind_reg;
    assign stat.item_short     = short_reg;
    assign stat.rot_infeasible = rot_inf;
    assign stat.root_done      = !root_busy;
    assign stat.out_busy       = out_valid_reg && out_stall;

    assign out_valid         = out_valid_reg;
    assign result_tag        = out_tag_reg;
    assign status            = out_status_reg;
    assign lead_first_index  = out_i1_reg;
    assign lead_first_value  = signed'(out_v1_reg);
    assign lead_second_index = out_i2_reg;
    assign lead_second_value = signed'(out_v2_reg);

endmodule

`default_nettype wire

/* sv/socc_ctrl.sv */
// Controller state machine: sequences element intake, squaring and the per-cone verdict.
// Depends on socc_pkg; talks to socc_datapath through dp_cmd_t and dp_status_t.
`default_nettype none

module socc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire socc_pkg::dp_status_t stat,
    output socc_pkg::dp_cmd_t         cmd
);

    socc_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            socc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = socc_pkg::ST_ITEM;
                end
            end
            socc_pkg::ST_ITEM:
            begin
                if (stat.item_tail)
                begin
                    state_next = socc_pkg::ST_ACCUM;
                end
                else if (stat.item_last)
                begin
                    state_next = socc_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = socc_pkg::ST_IDLE;
                end
            end
            socc_pkg::ST_ACCUM:
            begin
                state_next = stat.item_last ? socc_pkg::ST_DECIDE : socc_pkg::ST_IDLE;
            end
            socc_pkg::ST_DECIDE:
            begin
                if (!stat.item_rotated)
                begin
                    state_next = socc_pkg::ST_ROOT_WAIT;
                end
                else if (stat.item_short)
                begin
                    state_next = socc_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = socc_pkg::ST_CROSS;
                end
            end
            socc_pkg::ST_CROSS:
            begin
                state_next = socc_pkg::ST_ROT_TEST;
            end
            socc_pkg::ST_ROT_TEST:
            begin
                state_next = stat.rot_infeasible ? socc_pkg::ST_DIFF : socc_pkg::ST_FINISH;
            end
            socc_pkg::ST_DIFF:
            begin
                state_next = socc_pkg::ST_ROOT_START;
            end
            socc_pkg::ST_ROOT_START:
            begin
                state_next = socc_pkg::ST_ROOT_WAIT;
            end
            socc_pkg::ST_ROOT_WAIT:
            begin
                if (stat.root_done)
                begin
                    state_next = socc_pkg::ST_FINISH;
                end
            end
            socc_pkg::ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = socc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = socc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = socc_pkg::MUL_TAIL;
        in_stall     = 1'b1;
        case (state_reg)
            socc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            socc_pkg::ST_ITEM:
            begin
                cmd.mul_en = stat.item_tail;
            end
            socc_pkg::ST_ACCUM:
            begin
                cmd.acc_en = 1'b1;
            end
            socc_pkg::ST_DECIDE:
            begin
                cmd.root_start = !stat.item_rotated;
                cmd.mul_en     = stat.item_rotated && !stat.item_short;
                cmd.mul_sel    = socc_pkg::MUL_CROSS;
            end
            socc_pkg::ST_CROSS:
            begin
                cmd.cross_en = 1'b1;
            end
            socc_pkg::ST_ROT_TEST:
            begin
                cmd.rot_test_en = 1'b1;
                cmd.mul_en      = stat.rot_infeasible;
                cmd.mul_sel     = socc_pkg::MUL_DIFF;
            end
            socc_pkg::ST_DIFF:
            begin
                cmd.rad_en = 1'b1;
            end
            socc_pkg::ST_ROOT_START:
            begin
                cmd.root_start    = 1'b1;
                cmd.root_from_rad = 1'b1;
            end
            socc_pkg::ST_FINISH:
            begin
                // hold the verdict until the output register frees up
                cmd.verdict_en = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= socc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* sv/second_order_cone_check_project.sv */
// Top level of the second-order cone check: controller plus datapath.
// Depends on socc_pkg, socc_ctrl and socc_datapath.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    cone_kind, cone_tag, member_index,
//                                               element_value, last_element
//   output    out        out_valid / out_stall  result_tag, status, lead_* fields
//   config    in         cfg_write              cfg_data (feasibility tolerance)
//
// An element that is not last passes through ITEM, and through ACCUM too when it
// belongs to the tail sum. A last element adds DECIDE, CROSS and ROT_TEST for a
// feasible rotated cone; when a root is needed it waits on the 32-step root unit.
// Reset is asynchronous, active low; it clears the cone state and sets the
// tolerance to 17. A result waits in the output register under out_stall while
// the next cone's elements are taken; a second verdict waits for it.
`default_nettype none

module second_order_cone_check_project #(
    parameter int VALUE_WIDTH   = socc_pkg::DEF_VALUE_WIDTH,
    parameter int FRACTION_BITS = socc_pkg::DEF_FRACTION_BITS,
    parameter int INDEX_WIDTH   = socc_pkg::DEF_INDEX_WIDTH,
    parameter int MAX_CONE_SIZE = socc_pkg::DEF_MAX_CONE_SIZE
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [socc_pkg::TOL_WIDTH-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               cone_kind,
    input  wire logic [socc_pkg::TAG_WIDTH-1:0]     cone_tag,
    input  wire logic [INDEX_WIDTH-1:0]             member_index,
    input  wire logic signed [VALUE_WIDTH-1:0]      element_value,
    input  wire logic                               last_element,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [socc_pkg::TAG_WIDTH-1:0]          result_tag,
    output logic [socc_pkg::STATUS_WIDTH-1:0]       status,
    output logic [INDEX_WIDTH-1:0]                  lead_first_index,
    output logic signed [VALUE_WIDTH-1:0]           lead_first_value,
    output logic [INDEX_WIDTH-1:0]                  lead_second_index,
    output logic signed [VALUE_WIDTH-1:0]           lead_second_value
);

    socc_pkg::dp_cmd_t    cmd;
    socc_pkg::dp_status_t stat;

    socc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    socc_datapath #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .INDEX_WIDTH   (INDEX_WIDTH),
        .MAX_CONE_SIZE (MAX_CONE_SIZE)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_write         (cfg_write),
        .cfg_data          (cfg_data),
        .cone_kind         (cone_kind),
        .cone_tag          (cone_tag),
        .member_index      (member_index),
        .element_value     (element_value),
        .last_element      (last_element),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .result_tag        (result_tag),
        .status            (status),
        .lead_first_index  (lead_first_index),
        .lead_first_value  (lead_first_value),
        .lead_second_index (lead_second_index),
        .lead_second_value (lead_second_value)
    );

endmodule

`default_nettype wire

/* test/tb_second_order_cone_check_project.sv */
`timescale 1ns / 100ps
// Self-checking testbench for second_order_cone_check_project: streams cones
// element by element and checks each verdict against an in-bench predictor.
// Depends on socc_pkg and the top level only.

module tb_second_order_cone_check_project;

    localparam int VW = socc_pkg::DEF_VALUE_WIDTH;
    localparam int FB = socc_pkg::DEF_FRACTION_BITS;
    localparam int IW = socc_pkg::DEF_INDEX_WIDTH;
    localparam int MAX_POS = socc_pkg::DEF_MAX_CONE_SIZE;
    localparam int TAGW = socc_pkg::TAG_WIDTH;
    localparam int TOLW = socc_pkg::TOL_WIDTH;
    localparam int STW = socc_pkg::STATUS_WIDTH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic                  kind;
        logic [TAGW-1:0]       tag;
        logic [IW-1:0]         index;
        logic signed [VW-1:0]  value;
        logic                  last;
    } element_t;

    typedef struct packed {
        logic [TAGW-1:0]         tag;
        socc_pkg::status_code_t  status;
        logic [IW-1:0]           first_index;
        logic signed [VW-1:0]    first_value;
        logic [IW-1:0]           second_index;
        logic signed [VW-1:0]    second_value;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [TOLW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cone_kind = 1'b0;
    logic [TAGW-1:0] cone_tag = '0;
    logic [IW-1:0] member_index = '0;
    logic signed [VW-1:0] element_value = '0;
    logic last_element = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [TAGW-1:0] result_tag;
    logic [STW-1:0] status;
    logic [IW-1:0] lead_first_index;
    logic signed [VW-1:0] lead_first_value;
    logic [IW-1:0] lead_second_index;
    logic signed [VW-1:0] lead_second_value;

    element_t pending_elements[$];
    verdict_t expected_verdicts[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    logic element_taken = 1'b0;

    // predictor state
    logic [TOLW-1:0] tol_model;
    logic [63:0] tail_sum;
    logic signed [63:0] lead0_value, lead1_value;
    logic [IW-1:0] lead0_index, lead1_index;
    int element_pos;

    second_order_cone_check_project dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cone_kind(cone_kind), .cone_tag(cone_tag), .member_index(member_index),
        .element_value(element_value), .last_element(last_element),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_tag(result_tag), .status(status),
        .lead_first_index(lead_first_index), .lead_first_value(lead_first_value),
        .lead_second_index(lead_second_index), .lead_second_value(lead_second_value)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    function automatic logic [63:0] magnitude(logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [VW-1:0] clamp_lead(logic signed [63:0] v);
        logic [63:0] h;
        if (v < 0)
            return '0;
        h = v >>> 1;
        return (h > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : h[VW-1:0];
    endfunction

    function automatic void clear_cone();
        tail_sum = 0;
        lead0_value = 0;
        lead1_value = 0;
        lead0_index = 0;
        lead1_index = 0;
        element_pos = 0;
    endfunction

    // Advance the cone state by one element; return 1 with a verdict on the last one.
    function automatic bit cone_step(element_t e, output verdict_t v);
        logic signed [63:0] x, d, lo, hi;
        logic [63:0] s, p, tolq, rad, m;
        int pos;
        bit neg, infeasible;
        x = e.value;
        pos = element_pos;
        v = '0;
        if (pos == 0)
        begin
            lead0_value = x;
            lead0_index = e.index;
        end
        else if (pos == 1)
        begin
            lead1_value = x;
            lead1_index = e.index;
        end
        if (pos >= (e.kind ? 2 : 1))
        begin
            m = magnitude(x);
            tail_sum = sat_add(tail_sum, sat_mul(m, m));
        end
        if (element_pos < MAX_POS)
            element_pos++;
        if (!e.last)
            return 0;
        v.tag = e.tag;
        v.status = socc_pkg::STATUS_FEASIBLE;
        v.first_index = lead0_index;
        if (!e.kind)
        begin
            s = floor_root(tail_sum);
            if (lead0_value + $signed({39'd0, tol_model}) < $signed(s))
            begin
                v.status = socc_pkg::STATUS_PROJECTED;
                v.first_value = (s > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : s[VW-1:0];
            end
        end
        else if (pos == 0)
            v.status = socc_pkg::STATUS_SHORT;
        else
        begin
            neg = (lead0_value < 0) != (lead1_value < 0);
            tolq = {39'd0, tol_model} << FB;
            p = sat_mul(magnitude(lead0_value), magnitude(lead1_value));
            p = sat_add(p, p);
            if (p == 0)
                neg = 0;
            if (!neg)
                infeasible = sat_add(p, tolq) < tail_sum;
            else if (p > tolq)
                infeasible = 1;
            else if (p == tolq)
                infeasible = tail_sum > 0;
            else
                infeasible = (tolq - p) < tail_sum;
            v.second_index = lead1_index;
            if (infeasible)
            begin
                d = lead1_value - lead0_value;
                m = magnitude(d);
                rad = sat_add(sat_mul(m, m), sat_add(tail_sum, tail_sum));
                s = floor_root(rad);
                lo = $signed(s) - d;
                hi = $signed(s) + d;
                v.status = socc_pkg::STATUS_PROJECTED;
                v.first_value = clamp_lead(lo);
                v.second_value = clamp_lead(hi);
            end
        end
        clear_cone();
        return 1;
    endfunction

    // Input side: track acceptance, predict, and drive in bursts.
    always @(posedge clk)
    begin
        verdict_t v;
        element_t e;
        cycle_count <= cycle_count + 1;
        element_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            e = '{cone_kind, cone_tag, member_index, element_value, last_element};
            if (cone_step(e, v))
                expected_verdicts.push_back(v);
        end
    end

    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        element_t e;
        if (rst_n && !(in_valid && !element_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_elements.size() > 0)
            begin
                e = pending_elements.pop_front();
                {cone_kind, cone_tag, member_index, element_value, last_element} <= e;
                in_valid <= 1'b1;
                if (burst_left <= 0)
                    burst_left = $urandom_range(1, 24);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side: stall pattern with modes, plus long hold-offs.
    int hold_left = 0;
    int mode_left = 0;
    int stall_pct = 0;

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (cycle_count == 3000 || cycle_count == 40000)
        begin
            hold_left = 400;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left <= 0)
            begin
                mode_left = $urandom_range(20, 200);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    default: stall_pct = 75;
                endcase
            end
            mode_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        verdict_t x;
        if (out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("verdict for tag %0d with none expected", result_tag);
                mismatch_count++;
            end
            else
            begin
                x = expected_verdicts.pop_front();
                if (result_tag !== x.tag)
                begin
                    $error("result_tag: expected %0d, got %0d", x.tag, result_tag);
                    mismatch_count++;
                end
                if (status !== x.status)
                begin
                    $error("status: expected %0d, got %0d", x.status, status);
                    mismatch_count++;
                end
                if (lead_first_index !== x.first_index)
                begin
                    $error("lead_first_index: expected %0d, got %0d",
                           x.first_index, lead_first_index);
                    mismatch_count++;
                end
                if (lead_first_value !== x.first_value)
                begin
                    $error("lead_first_value: expected %0d, got %0d",
                           x.first_value, lead_first_value);
                    mismatch_count++;
                end
                if (lead_second_index !== x.second_index)
                begin
                    $error("lead_second_index: expected %0d, got %0d",
                           x.second_index, lead_second_index);
                    mismatch_count++;
                end
                if (lead_second_value !== x.second_value)
                begin
                    $error("lead_second_value: expected %0d, got %0d",
                           x.second_value, lead_second_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [VW-1:0] pick_value(int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            2: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            default:
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
        endcase
    endfunction

    // Queue one cone; returns its element count.
    function automatic int queue_cone(logic kind, int count, int style, bit mix_kind);
        element_t e;
        logic [TAGW-1:0] tag;
        tag = TAGW'($urandom);
        for (int i = 0; i < count; i++)
        begin
            e.kind = (mix_kind && $urandom_range(0, 3) == 0) ? ~kind : kind;
            e.tag = tag;
            e.index = IW'($urandom);
            e.value = pick_value(style);
            e.last = (i == count - 1);
            pending_elements.push_back(e);
        end
        return count;
    endfunction

    function automatic void queue_fixed(logic kind, logic [TAGW-1:0] tag,
                                        logic [IW-1:0] index, logic signed [VW-1:0] value,
                                        logic last);
        pending_elements.push_back('{kind, tag, index, value, last});
    endfunction

    task automatic wait_idle();
        while (pending_elements.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_tolerance(logic [TOLW-1:0] value);
        cfg_write <= 1'b1;
        cfg_data <= value;
        tol_model = value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [TOLW-1:0] tolerances[5];
        int queued, style, n;
        tol_model = socc_pkg::TOL_RESET;
        clear_cone();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, short rotated cone, kind change, sign mix
        queue_fixed(1'b0, 12'h000, 16'h0000, 32'sh7FFF_FFFF, 1'b1);
        queue_fixed(1'b0, 12'hFFF, 16'hFFFF, 32'sh8000_0000, 1'b1);
        queue_fixed(1'b1, 12'h001, 16'hFFFF, 32'sh0100_0000, 1'b1);
        queue_fixed(1'b1, 12'h002, 16'h0001, 32'sh0100_0000, 1'b0);
        queue_fixed(1'b1, 12'h002, 16'h0002, 32'sh0100_0000, 1'b1);
        queue_fixed(1'b1, 12'h003, 16'h0000, 32'sh8000_0000, 1'b0);
        queue_fixed(1'b1, 12'h003, 16'hFFFF, 32'sh7FFF_FFFF, 1'b0);
        queue_fixed(1'b1, 12'h003, 16'h1234, 32'sh7FFF_FFFF, 1'b1);
        queue_fixed(1'b1, 12'h004, 16'h0010, 32'sh0000_0000, 1'b0);
        queue_fixed(1'b1, 12'h004, 16'h0011, -32'sh0100_0000, 1'b0);
        queue_fixed(1'b1, 12'h004, 16'h0012, 32'sh0000_0100, 1'b1);
        queue_fixed(1'b0, 12'h005, 16'h0020, 32'sh0000_0000, 1'b0);
        queue_fixed(1'b0, 12'h005, 16'h0021, 32'sh8000_0000, 1'b0);
        queue_fixed(1'b0, 12'h005, 16'h0022, 32'sh7FFF_FFFF, 1'b1);
        queue_fixed(1'b0, 12'h006, 16'h0030, 32'sh0300_0000, 1'b0);
        queue_fixed(1'b1, 12'h006, 16'h0031, 32'sh0100_0000, 1'b0);
        queue_fixed(1'b0, 12'h006, 16'h0032, 32'sh0200_0000, 1'b1);
        queue_fixed(1'b1, 12'h007, 16'h0040, -32'sh0200_0000, 1'b0);
        queue_fixed(1'b1, 12'h007, 16'h0041, 32'sh0100_0000, 1'b0);
        queue_fixed(1'b1, 12'h007, 16'h0042, 32'sh0000_0001, 1'b1);
        queue_fixed(1'b0, 12'h008, 16'h0050, 32'sh0000_0000, 1'b1);
        wait_idle();

        tolerances[0] = 25'd0;
        tolerances[1] = 25'h1FF_FFFF;
        tolerances[2] = 25'd16777216;
        tolerances[3] = TOLW'($urandom_range(0, 25'h000_FFFF));
        tolerances[4] = 25'd17;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_tolerance(tolerances[phase]);
            queued = 0;
            // over-long cone drives the tail sum into saturation
            if (phase == 1)
                queued += queue_cone(1'b0, 300, 3, 1'b0);
            while (queued < 300)
            begin
                style = $urandom_range(0, 3);
                n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
                queued += queue_cone(1'($urandom_range(0, 1)), n, style,
                                     $urandom_range(0, 9) == 0);
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
sv/socc_pkg.sv
sv/socc_isqrt.sv
sv/socc_datapath.sv
sv/socc_ctrl.sv
sv/second_order_cone_check_project.sv
test/tb_second_order_cone_check_project.sv
